FILE: rtl/fbdt_pkg.sv
// Package for the framebuffer fill and dirty-box tracker.
// Field widths, command and status codes, address unit ops and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package fbdt_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int COLOR_BITS_DEF = 32;

    localparam int REQ_W    = 3;
    localparam int POS_W    = 8;
    localparam int DIM_W    = 9;
    localparam int COLOR_W  = 32;
    localparam int STATUS_W = 2;
    localparam int PIXEL_W  = 32;
    localparam int BIT_CNT_W = $clog2(POS_W);

    // y * width + x needs one bit more than the product
    localparam int ADDR_CALC_W = POS_W + DIM_W + 1;

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    localparam logic [REQ_W-1:0] REQ_DRAW   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RECT   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CANVAS = 3'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_HORIZ = 2'd1;
    localparam logic [STATUS_W-1:0] ST_VERT  = 2'd2;

    localparam logic REG_CANVAS_W = 1'b0;
    localparam logic REG_CANVAS_H = 1'b1;

    localparam logic [2:0] AU_HOLD = 3'd0;
    localparam logic [2:0] AU_CLR  = 3'd1;
    localparam logic [2:0] AU_MUL  = 3'd2;
    localparam logic [2:0] AU_ADDX = 3'd3;
    localparam logic [2:0] AU_INC  = 3'd4;
    localparam logic [2:0] AU_SKIP = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic       mul_bit;
    } fbdt_au_ctrl_t;

    typedef struct packed {
        logic we;
        logic re;
    } fbdt_mem_ctrl_t;

    typedef struct packed {
        logic [DIM_W-1:0] cw;
        logic [DIM_W-1:0] ch;
    } fbdt_dims_t;

endpackage

FILE: rtl/fbdt_channels.sv
// Valid/ready channel interfaces: command beats in, result beats out.
// Depends on fbdt_pkg.
`timescale 1ns / 1ps

interface fbdt_req_if;
    logic                          valid;
    logic                          ready;
    logic [fbdt_pkg::REQ_W-1:0]    req_type;
    logic [fbdt_pkg::POS_W-1:0]    pos_x;
    logic [fbdt_pkg::POS_W-1:0]    pos_y;
    logic [fbdt_pkg::DIM_W-1:0]    rect_width;
    logic [fbdt_pkg::DIM_W-1:0]    rect_height;
    logic [fbdt_pkg::COLOR_W-1:0]  color;

    modport source (
        output valid, req_type, pos_x, pos_y, rect_width, rect_height, color,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, rect_width, rect_height, color,
        output ready
    );
endinterface

interface fbdt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fbdt_pkg::STATUS_W-1:0] status;
    logic [fbdt_pkg::PIXEL_W-1:0]  pixel_value;
    logic                          dirty_valid;
    logic [fbdt_pkg::POS_W-1:0]    dirty_left;
    logic [fbdt_pkg::POS_W-1:0]    dirty_top;
    logic [fbdt_pkg::POS_W-1:0]    dirty_right;
    logic [fbdt_pkg::POS_W-1:0]    dirty_bottom;

    modport source (
        output valid, status, pixel_value, dirty_valid,
               dirty_left, dirty_top, dirty_right, dirty_bottom,
        input  ready
    );
    modport sink (
        input  valid, status, pixel_value, dirty_valid,
               dirty_left, dirty_top, dirty_right, dirty_bottom,
        output ready
    );
endinterface

FILE: rtl/framebuffer_fill_dirty_tracker_top.sv
// Usage
// Top level of the framebuffer fill engine with dirty-box tracking.
// Depends on fbdt_pkg, fbdt_channels, fbdt_apb_regs, fbdt_addr_unit, fbdt_store, fbdt_seq.
//
// Channels: req carries one command a beat (draw pixel, fill rectangle, fill
// canvas, read pixel, clear dirty); rsp returns one result beat per command
// with status, read pixel and the dirty box after the command. The APB port
// sets canvas width (address 0) and height (address 4); write them only idle.
// Rejected commands, clear dirty and zero-sized rectangles go straight to the
// result register. Draw pixel, fill rectangle, fill canvas and read pixel first
// form row*width on the shared address adder (8 shift-add steps), add the column
// in one step, then use the single-port pixel store: a fill writes one pixel
// per cycle, a read reads one word and captures it.
// One command is in flight at a time; req.ready is high only when idle, so the
// next beat can be taken as early as the cycle in which the result is offered.
// The result sits in an output register; a stalled receiver holds the
// sequencer at its final step until the register drains.
// Reset clears the dirty box and restores the canvas size to the store size;
// pixel contents are undefined until written.
`timescale 1ns / 1ps

module framebuffer_fill_dirty_tracker_top #(
    parameter int MAX_WIDTH  = fbdt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbdt_pkg::MAX_HEIGHT_DEF,
    parameter int COLOR_BITS = fbdt_pkg::COLOR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    fbdt_req_if.sink                          req,
    fbdt_rsp_if.source                        rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fbdt_pkg::PADDR_W-1:0]      paddr,
    input  logic [fbdt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fbdt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import fbdt_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int ACC_W = (AW > ADDR_CALC_W) ? AW : ADDR_CALC_W;

    fbdt_dims_t          dims;
    fbdt_au_ctrl_t       au_ctrl;
    fbdt_mem_ctrl_t      mem_ctrl;
    logic [POS_W-1:0]    x_base;
    logic [DIM_W-1:0]    row_skip;
    logic [COLOR_W-1:0]  wr_color;
    logic [ACC_W-1:0]    acc;
    logic [COLOR_BITS-1:0] rdata;

    fbdt_apb_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dims    (dims)
    );

    fbdt_addr_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr (
        .clk  (clk),
        .ctrl (au_ctrl),
        .cw   (dims.cw),
        .x    (x_base),
        .skip (row_skip),
        .acc  (acc)
    );

    fbdt_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COLOR_BITS (COLOR_BITS)
    ) u_store (
        .clk   (clk),
        .ctrl  (mem_ctrl),
        .addr  (acc[AW-1:0]),
        .color (wr_color),
        .rdata (rdata)
    );

    fbdt_seq #(
        .COLOR_BITS (COLOR_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .dims     (dims),
        .rdata    (rdata),
        .au_ctrl  (au_ctrl),
        .mem_ctrl (mem_ctrl),
        .x_base   (x_base),
        .row_skip (row_skip),
        .wr_color (wr_color)
    );

endmodule

FILE: rtl/fbdt_apb_regs.sv
// Canvas size registers behind an APB-style write/read port.
// Presents the clamped (effective) canvas size. Depends on fbdt_pkg.
`timescale 1ns / 1ps

module fbdt_apb_regs #(
    parameter int MAX_WIDTH  = fbdt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbdt_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fbdt_pkg::PADDR_W-1:0]      paddr,
    input  logic [fbdt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fbdt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output fbdt_pkg::fbdt_dims_t              dims
);
    import fbdt_pkg::*;

    localparam int DIM_MAX   = (1 << DIM_W) - 1;
    localparam int LIM_W     = (MAX_WIDTH  > DIM_MAX) ? DIM_MAX : MAX_WIDTH;
    localparam int LIM_H     = (MAX_HEIGHT > DIM_MAX) ? DIM_MAX : MAX_HEIGHT;
    localparam logic [DIM_W-1:0] LIM_W_V = DIM_W'(LIM_W);
    localparam logic [DIM_W-1:0] LIM_H_V = DIM_W'(LIM_H);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             wr_en;
    logic             reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= LIM_W_V;
            height_reg <= LIM_H_V;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_CANVAS_W)
            begin
                width_reg <= pwdata[DIM_W-1:0];
            end
            else
            begin
                height_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (reg_sel == REG_CANVAS_W)
        begin
            prdata = APB_DATA_W'(width_reg);
        end
        else
        begin
            prdata = APB_DATA_W'(height_reg);
        end
    end

    // zero acts as one, anything above the store size as the store size
    always_comb
    begin
        if (width_reg == '0)
        begin
            dims.cw = DIM_W'(1);
        end
        else if (width_reg > LIM_W_V)
        begin
            dims.cw = LIM_W_V;
        end
        else
        begin
            dims.cw = width_reg;
        end

        if (height_reg == '0)
        begin
            dims.ch = DIM_W'(1);
        end
        else if (height_reg > LIM_H_V)
        begin
            dims.ch = LIM_H_V;
        end
        else
        begin
            dims.ch = height_reg;
        end
    end

endmodule

FILE: rtl/fbdt_addr_unit.sv
// Shared address accumulator: one adder used for the shift-add row multiply,
// the column offset, and the per-pixel and per-row steps. Depends on fbdt_pkg.
`timescale 1ns / 1ps

module fbdt_addr_unit #(
    parameter int MAX_WIDTH  = fbdt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbdt_pkg::MAX_HEIGHT_DEF,
    localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int ACC_W = (AW > fbdt_pkg::ADDR_CALC_W) ? AW : fbdt_pkg::ADDR_CALC_W
) (
    input  logic                          clk,
    input  fbdt_pkg::fbdt_au_ctrl_t       ctrl,
    input  logic [fbdt_pkg::DIM_W-1:0]    cw,
    input  logic [fbdt_pkg::POS_W-1:0]    x,
    input  logic [fbdt_pkg::DIM_W-1:0]    skip,
    output logic [ACC_W-1:0]              acc
);
    import fbdt_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] opa;
    logic [ACC_W-1:0] opb;
    logic [ACC_W-1:0] sum;

    always_comb
    begin
        opa = (ctrl.op == AU_MUL) ? {acc_reg[ACC_W-2:0], 1'b0} : acc_reg;
        case (ctrl.op)
            AU_MUL:  opb = ctrl.mul_bit ? ACC_W'(cw) : '0;
            AU_ADDX: opb = ACC_W'(x);
            AU_INC:  opb = ACC_W'(1);
            AU_SKIP: opb = ACC_W'(skip);
            default: opb = '0;
        endcase
        sum = opa + opb;

        case (ctrl.op)
            AU_HOLD: acc_next = acc_reg;
            AU_CLR:  acc_next = '0;
            default: acc_next = sum;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/fbdt_store.sv
// Pixel store: single-port memory, one write or one registered read a cycle.
// Depends on fbdt_pkg.
`timescale 1ns / 1ps

module fbdt_store #(
    parameter int MAX_WIDTH  = fbdt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fbdt_pkg::MAX_HEIGHT_DEF,
    parameter int COLOR_BITS = fbdt_pkg::COLOR_BITS_DEF,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                            clk,
    input  fbdt_pkg::fbdt_mem_ctrl_t        ctrl,
    input  logic [AW-1:0]                   addr,
    input  logic [fbdt_pkg::COLOR_W-1:0]    color,
    output logic [COLOR_BITS-1:0]           rdata
);
    import fbdt_pkg::*;

    logic [COLOR_BITS-1:0] mem [DEPTH];
    logic [COLOR_BITS-1:0] wdata;

    assign wdata = COLOR_BITS'(color);

    always_ff @(posedge clk)
    begin
        if (ctrl.we)
        begin
            mem[addr] <= wdata;
        end
        if (ctrl.re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: rtl/fbdt_seq.sv
// Command sequencer: range checks, multiply/offset/fill steps driving the
// address unit and store, dirty box tracking and result register. Uses fbdt_pkg.
`timescale 1ns / 1ps

module fbdt_seq #(
    parameter int COLOR_BITS = fbdt_pkg::COLOR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fbdt_req_if.sink                      req,
    fbdt_rsp_if.source                    rsp,
    input  fbdt_pkg::fbdt_dims_t          dims,
    input  logic [COLOR_BITS-1:0]         rdata,
    output fbdt_pkg::fbdt_au_ctrl_t       au_ctrl,
    output fbdt_pkg::fbdt_mem_ctrl_t      mem_ctrl,
    output logic [fbdt_pkg::POS_W-1:0]    x_base,
    output logic [fbdt_pkg::DIM_W-1:0]    row_skip,
    output logic [fbdt_pkg::COLOR_W-1:0]  wr_color
);
    import fbdt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ADDX  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_RDCAP = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]           state_reg, state_next;
    logic [REQ_W-1:0]     cmd_reg, cmd_next;
    logic [POS_W-1:0]     x_reg, x_next;
    logic [POS_W-1:0]     y_reg, y_next;
    logic [DIM_W-1:0]     w_reg, w_next;
    logic [DIM_W-1:0]     h_reg, h_next;
    logic [DIM_W-1:0]     skip_reg, skip_next;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 wr_reg, wr_next;
    logic                 rd_reg, rd_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [DIM_W-1:0]     col_reg, col_next;
    logic [DIM_W-1:0]     row_reg, row_next;
    logic [PIXEL_W-1:0]   pix_reg, pix_next;

    logic                 dirty_reg, dirty_next;
    logic [POS_W-1:0]     left_reg, left_next;
    logic [POS_W-1:0]     top_reg, top_next;
    logic [POS_W-1:0]     right_reg, right_next;
    logic [POS_W-1:0]     bottom_reg, bottom_next;

    logic                 ovalid_reg, ovalid_next;
    logic [STATUS_W-1:0]  ostatus_reg, ostatus_next;
    logic [PIXEL_W-1:0]   opix_reg, opix_next;
    logic                 odirty_reg, odirty_next;
    logic [POS_W-1:0]     oleft_reg, oleft_next;
    logic [POS_W-1:0]     otop_reg, otop_next;
    logic [POS_W-1:0]     oright_reg, oright_next;
    logic [POS_W-1:0]     obottom_reg, obottom_next;

    logic                 accept;
    logic                 out_free;
    logic [DIM_W:0]       x_end;
    logic [DIM_W:0]       y_end;
    logic [STATUS_W-1:0]  dec_status;
    logic [POS_W-1:0]     dec_x, dec_y;
    logic [DIM_W-1:0]     dec_w, dec_h;
    logic                 dec_wr, dec_rd;
    logic [DIM_W:0]       r_new, b_new;
    logic                 col_last, row_last;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !ovalid_reg || rsp.ready;

    assign x_base   = x_reg;
    assign row_skip = skip_reg;
    assign wr_color = color_reg;

    // command decode and range checks, horizontal first
    always_comb
    begin
        x_end = (DIM_W+1)'(req.pos_x) + (DIM_W+1)'(req.rect_width);
        y_end = (DIM_W+1)'(req.pos_y) + (DIM_W+1)'(req.rect_height);
        dec_status = ST_OK;
        dec_x  = req.pos_x;
        dec_y  = req.pos_y;
        dec_w  = DIM_W'(1);
        dec_h  = DIM_W'(1);
        dec_wr = 1'b0;
        dec_rd = 1'b0;
        if (req.req_type inside {REQ_DRAW, REQ_READ})
        begin
            if (DIM_W'(req.pos_x) >= dims.cw)
            begin
                dec_status = ST_HORIZ;
            end
            else if (DIM_W'(req.pos_y) >= dims.ch)
            begin
                dec_status = ST_VERT;
            end
            else
            begin
                dec_wr = (req.req_type == REQ_DRAW);
                dec_rd = (req.req_type == REQ_READ);
            end
        end
        else if (req.req_type == REQ_RECT)
        begin
            dec_w = req.rect_width;
            dec_h = req.rect_height;
            if (x_end > (DIM_W+1)'(dims.cw))
            begin
                dec_status = ST_HORIZ;
            end
            else if (y_end > (DIM_W+1)'(dims.ch))
            begin
                dec_status = ST_VERT;
            end
            else
            begin
                dec_wr = (req.rect_width != '0) && (req.rect_height != '0);
            end
        end
        else if (req.req_type == REQ_CANVAS)
        begin
            dec_x  = '0;
            dec_y  = '0;
            dec_w  = dims.cw;
            dec_h  = dims.ch;
            dec_wr = 1'b1;
        end
    end

    assign col_last = ((DIM_W+1)'(col_reg) + (DIM_W+1)'(1)) == (DIM_W+1)'(w_reg);
    assign row_last = ((DIM_W+1)'(row_reg) + (DIM_W+1)'(1)) == (DIM_W+1)'(h_reg);
    assign r_new    = (DIM_W+1)'(x_reg) + (DIM_W+1)'(w_reg) - (DIM_W+1)'(1);
    assign b_new    = (DIM_W+1)'(y_reg) + (DIM_W+1)'(h_reg) - (DIM_W+1)'(1);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        w_next      = w_reg;
        h_next      = h_reg;
        skip_next   = skip_reg;
        color_next  = color_reg;
        status_next = status_reg;
        wr_next     = wr_reg;
        rd_next     = rd_reg;
        bit_next    = bit_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pix_next    = pix_reg;
        dirty_next  = dirty_reg;
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        au_ctrl     = '{op: AU_HOLD, mul_bit: 1'b0};
        mem_ctrl    = '{we: 1'b0, re: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = req.req_type;
                    x_next      = dec_x;
                    y_next      = dec_y;
                    w_next      = dec_w;
                    h_next      = dec_h;
                    skip_next   = dims.cw - dec_w + DIM_W'(1);
                    color_next  = req.color;
                    status_next = dec_status;
                    wr_next     = dec_wr;
                    rd_next     = dec_rd;
                    bit_next    = '0;
                    au_ctrl.op  = AU_CLR;
                    state_next  = (dec_wr || dec_rd) ? S_MUL : S_DONE;
                end
            end
            S_MUL:
            begin
                // MSB first: acc = 2*acc + bit * width
                au_ctrl.op      = AU_MUL;
                au_ctrl.mul_bit = y_reg[~bit_reg];
                bit_next        = bit_reg + BIT_CNT_W'(1);
                if (bit_reg == BIT_CNT_W'(POS_W - 1))
                begin
                    state_next = S_ADDX;
                end
            end
            S_ADDX:
            begin
                au_ctrl.op = AU_ADDX;
                col_next   = '0;
                row_next   = '0;
                state_next = wr_reg ? S_WRITE : S_READ;
            end
            S_WRITE:
            begin
                mem_ctrl.we = 1'b1;
                if (col_last)
                begin
                    if (row_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        au_ctrl.op = AU_SKIP;
                        col_next   = '0;
                        row_next   = row_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    au_ctrl.op = AU_INC;
                    col_next   = col_reg + DIM_W'(1);
                end
            end
            S_READ:
            begin
                mem_ctrl.re = 1'b1;
                state_next  = S_RDCAP;
            end
            S_RDCAP:
            begin
                pix_next   = PIXEL_W'(rdata);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if (cmd_reg == REQ_CLEAR)
                    begin
                        dirty_next  = 1'b0;
                        left_next   = '0;
                        top_next    = '0;
                        right_next  = '0;
                        bottom_next = '0;
                    end
                    else if (wr_reg)
                    begin
                        if (!dirty_reg)
                        begin
                            dirty_next  = 1'b1;
                            left_next   = x_reg;
                            top_next    = y_reg;
                            right_next  = r_new[POS_W-1:0];
                            bottom_next = b_new[POS_W-1:0];
                        end
                        else
                        begin
                            if (x_reg < left_reg)
                            begin
                                left_next = x_reg;
                            end
                            if (y_reg < top_reg)
                            begin
                                top_next = y_reg;
                            end
                            // compare before truncation to the box width
                            if (r_new > (DIM_W+1)'(right_reg))
                            begin
                                right_next = r_new[POS_W-1:0];
                            end
                            if (b_new > (DIM_W+1)'(bottom_reg))
                            begin
                                bottom_next = b_new[POS_W-1:0];
                            end
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ovalid_next  = ovalid_reg;
        ostatus_next = ostatus_reg;
        opix_next    = opix_reg;
        odirty_next  = odirty_reg;
        oleft_next   = oleft_reg;
        otop_next    = otop_reg;
        oright_next  = oright_reg;
        obottom_next = obottom_reg;
        if (state_reg == S_DONE && out_free)
        begin
            ovalid_next  = 1'b1;
            ostatus_next = status_reg;
            opix_next    = rd_reg ? pix_reg : '0;
            odirty_next  = dirty_next;
            oleft_next   = left_next;
            otop_next    = top_next;
            oright_next  = right_next;
            obottom_next = bottom_next;
        end
        else if (rsp.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            dirty_reg  <= 1'b0;
            left_reg   <= '0;
            top_reg    <= '0;
            right_reg  <= '0;
            bottom_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            dirty_reg  <= dirty_next;
            left_reg   <= left_next;
            top_reg    <= top_next;
            right_reg  <= right_next;
            bottom_reg <= bottom_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        skip_reg    <= skip_next;
        color_reg   <= color_next;
        status_reg  <= status_next;
        wr_reg      <= wr_next;
        rd_reg      <= rd_next;
        bit_reg     <= bit_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        pix_reg     <= pix_next;
        ostatus_reg <= ostatus_next;
        opix_reg    <= opix_next;
        odirty_reg  <= odirty_next;
        oleft_reg   <= oleft_next;
        otop_reg    <= otop_next;
        oright_reg  <= oright_next;
        obottom_reg <= obottom_next;
    end

    assign rsp.valid        = ovalid_reg;
    assign rsp.status       = ostatus_reg;
    assign rsp.pixel_value  = opix_reg;
    assign rsp.dirty_valid  = odirty_reg;
    assign rsp.dirty_left   = oleft_reg;
    assign rsp.dirty_top    = otop_reg;
    assign rsp.dirty_right  = oright_reg;
    assign rsp.dirty_bottom = obottom_reg;

`ifndef SYNTHESIS
    a_clean_box: assert property (@(posedge clk) disable iff (!rst_n)
        !dirty_reg |-> (left_reg == '0 && top_reg == '0 &&
                        right_reg == '0 && bottom_reg == '0))
        else $error("dirty box edges set while box invalid");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctrl.we |-> (status_reg == ST_OK && wr_reg))
        else $error("pixel write for a rejected command");

    a_fill_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WRITE |-> (col_reg < w_reg && row_reg < h_reg))
        else $error("fill counters beyond rectangle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer idle after accepting a beat");

    a_read_capture: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RDCAP |-> $past(mem_ctrl.re))
        else $error("read capture without a store read");
`endif

endmodule
